### rtl/rne_pkg.sv
// Shared types, constants and table functions for the Roman numeral encoder.
// No dependencies; used by rne_ctrl, rne_datapath and the top level.
package rne_pkg;

    localparam int VALUE_W   = 12;
    localparam int GLYPH_W   = 8;
    localparam int DIGIT_W   = 4;
    localparam int PLACE_W   = 2;
    localparam int IDX_W     = 2;
    localparam int LEN_W     = 3;
    localparam int PROD_W    = 14;
    localparam int NUM_PLACE = 4;

    localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

    // Place codes: units up to thousands
    localparam logic [PLACE_W-1:0] PLACE_UNITS     = 2'd0;
    localparam logic [PLACE_W-1:0] PLACE_TENS      = 2'd1;
    localparam logic [PLACE_W-1:0] PLACE_HUNDREDS  = 2'd2;
    localparam logic [PLACE_W-1:0] PLACE_THOUSANDS = 2'd3;

    // Letter role within a place: one, five, ten
    localparam logic [1:0] ROLE_ONE  = 2'd0;
    localparam logic [1:0] ROLE_FIVE = 2'd1;
    localparam logic [1:0] ROLE_TEN  = 2'd2;

    localparam logic [GLYPH_W-1:0] CH_I = 8'h49;
    localparam logic [GLYPH_W-1:0] CH_V = 8'h56;
    localparam logic [GLYPH_W-1:0] CH_X = 8'h58;
    localparam logic [GLYPH_W-1:0] CH_L = 8'h4C;
    localparam logic [GLYPH_W-1:0] CH_C = 8'h43;
    localparam logic [GLYPH_W-1:0] CH_D = 8'h44;
    localparam logic [GLYPH_W-1:0] CH_M = 8'h4D;
    localparam logic [GLYPH_W-1:0] CH_NONE = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic split;
        logic emit;
        logic bad;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic value_bad;
        logic split_done;
        logic emit_last;
    } t_status;

    // Decimal weight of a place
    function automatic logic [PROD_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
        logic [PROD_W-1:0] w;
        unique case (place)
            PLACE_UNITS:    w = 14'd1;
            PLACE_TENS:     w = 14'd10;
            PLACE_HUNDREDS: w = 14'd100;
            default:        w = 14'd1000;
        endcase
        return w;
    endfunction

    // Number of letters a digit produces in a place
    function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] d,
                                                   input logic [PLACE_W-1:0] place);
        logic [LEN_W-1:0] n;
        if (place == PLACE_THOUSANDS) begin
            n = d[LEN_W-1:0];
        end else begin
            unique case (d)
                4'd1, 4'd5:       n = 3'd1;
                4'd2, 4'd4, 4'd6,
                4'd9:             n = 3'd2;
                4'd3, 4'd7:       n = 3'd3;
                4'd8:             n = 3'd4;
                default:          n = 3'd0;
            endcase
        end
        return n;
    endfunction

    // Letter role at position idx of a digit's pattern
    function automatic logic [1:0] digit_role(input logic [DIGIT_W-1:0] d,
                                              input logic [IDX_W-1:0] idx);
        logic [1:0] r;
        r = ROLE_ONE;
        priority if (d == 4'd4 && idx == 2'd1) begin
            r = ROLE_FIVE;
        end else if (d == 4'd9 && idx == 2'd1) begin
            r = ROLE_TEN;
        end else if (d >= 4'd5 && d <= 4'd8 && idx == 2'd0) begin
            r = ROLE_FIVE;
        end else begin
            r = ROLE_ONE;
        end
        return r;
    endfunction

    // ASCII letter for a digit position in a place
    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [DIGIT_W-1:0] d,
                                                    input logic [PLACE_W-1:0] place,
                                                    input logic [IDX_W-1:0] idx);
        logic [1:0]         role;
        logic [GLYPH_W-1:0] g;
        role = digit_role(d, idx);
        unique case (place)
            PLACE_UNITS:    g = (role == ROLE_ONE) ? CH_I : (role == ROLE_FIVE) ? CH_V : CH_X;
            PLACE_TENS:     g = (role == ROLE_ONE) ? CH_X : (role == ROLE_FIVE) ? CH_L : CH_C;
            PLACE_HUNDREDS: g = (role == ROLE_ONE) ? CH_C : (role == ROLE_FIVE) ? CH_D : CH_M;
            default:        g = CH_M;
        endcase
        return g;
    endfunction

endpackage

### rtl/roman_numeral_encoder_core.sv
// Top level of the Roman numeral encoder: controller plus datapath.
// Depends on rne_pkg, rne_ctrl and rne_datapath.
//
// A request (start high while busy is low) takes a 12-bit value and returns its
// Roman numeral as ASCII letters, one per o_strobe pulse, o_last on the final
// letter. The receiver cannot stall: each letter is on the ports for exactly one
// cycle. A value of 0 or above 3999 returns a single result with glyph 0 and
// o_invalid set in the cycle after the request, and busy stays low. A valid
// value is split into decimal digits through one shared compare-and-subtract
// digit unit, one place per cycle from thousands down to units, then emits its
// letters in order, 3888 being the longest numeral. The next request may be
// made in the cycle busy drops, while the last letter is still on the output
// register.
module roman_numeral_encoder_core
    import rne_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] i_value,
    output logic               busy,
    output logic               o_strobe,
    output logic [GLYPH_W-1:0] o_glyph,
    output logic               o_last,
    output logic               o_invalid
);

    t_cmd    cmd;
    t_status status;

    rne_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    rne_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_value   (i_value),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_strobe  (o_strobe),
        .o_glyph   (o_glyph),
        .o_last    (o_last),
        .o_invalid (o_invalid)
    );

endmodule

### rtl/rne_ctrl.sv
// Sequencing state machine for the Roman numeral encoder.
// Depends on rne_pkg for the state, command and status types.
module rne_ctrl
    import rne_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_status.value_bad) begin
                        // out-of-range request answered at once
                        o_cmd.bad = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                o_cmd.split = 1'b1;
                if (i_status.split_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

### rtl/rne_datapath.sv
// Digit extraction, letter walk and output register of the encoder.
// Depends on rne_pkg for tables, widths and the command/status types.
module rne_datapath
    import rne_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [VALUE_W-1:0] i_value,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic               o_strobe,
    output logic [GLYPH_W-1:0] o_glyph,
    output logic               o_last,
    output logic               o_invalid
);

    logic [VALUE_W-1:0] r_rem;
    logic [PLACE_W-1:0] r_place;
    logic [IDX_W-1:0]   r_idx;
    logic [DIGIT_W-1:0] r_digit [NUM_PLACE];
    logic [NUM_PLACE-1:0] r_nz;
    logic               r_strobe;
    logic [GLYPH_W-1:0] r_glyph;
    logic               r_last;
    logic               r_invalid;

    // Digit unit: compare remainder against k * weight, k = 1..9
    logic [PROD_W-1:0]  weight;
    logic [DIGIT_W-1:0] dig;
    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] rem_next;

    always_comb begin
        weight = place_weight(r_place);
        dig    = '0;
        for (int k = 1; k <= 9; k++) begin
            if ({{(PROD_W-VALUE_W){1'b0}}, r_rem} >= PROD_W'(k) * weight) begin
                dig = DIGIT_W'(k);
            end
        end
        prod     = {{(PROD_W-DIGIT_W){1'b0}}, dig} * weight;
        rem_next = VALUE_W'({{(PROD_W-VALUE_W){1'b0}}, r_rem} - prod);
    end

    // Nonzero mask including the digit being written, for the first-place search
    logic [NUM_PLACE-1:0] nz_split;
    logic [PLACE_W-1:0]   first_place;

    always_comb begin
        nz_split          = r_nz;
        nz_split[r_place] = (dig != '0);
        first_place       = PLACE_UNITS;
        for (int p = 0; p < NUM_PLACE; p++) begin
            if (nz_split[p]) begin
                first_place = PLACE_W'(p);
            end
        end
    end

    // Letter walk: current place length, lower nonzero places
    logic [LEN_W-1:0]     cur_len;
    logic                 end_of_place;
    logic [NUM_PLACE-1:0] lower_nz;
    logic [PLACE_W-1:0]   next_place;
    logic [GLYPH_W-1:0]   cur_glyph;

    always_comb begin
        cur_len      = digit_len(r_digit[r_place], r_place);
        end_of_place = ({1'b0, r_idx} == cur_len - 3'd1);
        lower_nz     = r_nz & ((NUM_PLACE'(1) << r_place) - NUM_PLACE'(1));
        next_place   = PLACE_UNITS;
        for (int p = 0; p < NUM_PLACE; p++) begin
            if (lower_nz[p]) begin
                next_place = PLACE_W'(p);
            end
        end
        cur_glyph = glyph_of(r_digit[r_place], r_place, r_idx);
    end

    assign o_status.value_bad  = (i_value == '0) || (i_value > MAX_VALID);
    assign o_status.split_done = (r_place == PLACE_UNITS);
    assign o_status.emit_last  = end_of_place && (lower_nz == '0);

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= i_value;
            r_place <= PLACE_THOUSANDS;
            r_nz    <= '0;
        end else if (i_cmd.split) begin
            r_digit[r_place] <= dig;
            r_rem            <= rem_next;
            r_nz             <= nz_split;
            r_idx            <= '0;
            if (r_place == PLACE_UNITS) begin
                r_place <= first_place;
            end else begin
                r_place <= r_place - 2'd1;
            end
        end else if (i_cmd.emit) begin
            if (end_of_place) begin
                r_place <= next_place;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Output register: one result per strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit | i_cmd.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bad) begin
            r_glyph   <= CH_NONE;
            r_last    <= 1'b1;
            r_invalid <= 1'b1;
        end else if (i_cmd.emit) begin
            r_glyph   <= cur_glyph;
            r_last    <= o_status.emit_last;
            r_invalid <= 1'b0;
        end
    end

    assign o_strobe  = r_strobe;
    assign o_glyph   = r_glyph;
    assign o_last    = r_last;
    assign o_invalid = r_invalid;

endmodule
